>>> src/tgi_pkg.sv
// shared types, constants and register codes of the trilinear grid interpolator
// used by the front, the back and the top level
package tgi_pkg;

   localparam int GRID_WORDS_DEF = 262144;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int FRAC_MAX       = 24;
   localparam int QUEUE_DEPTH    = 16;
   localparam int OUT_DEPTH      = 16;
   localparam int REQ_DATA_W     = 200;
   localparam int CSR_ADDR_W     = 6;
   localparam int CSR_DATA_W     = 64;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // register indexes
   localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Z   = 3'd2;
   localparam logic [2:0] REG_INV_STEP_X = 3'd3;
   localparam logic [2:0] REG_INV_STEP_Y = 3'd4;
   localparam logic [2:0] REG_INV_STEP_Z = 3'd5;
   localparam logic [2:0] REG_COUNT_X    = 3'd6;
   localparam logic [2:0] REG_COUNT_Y    = 3'd7;

   typedef struct packed {
      logic [2:0][47:0] origin;
      logic [2:0][31:0] inv_step;
      logic [10:0]      count_x;
      logic [10:0]      count_y;
      logic [21:0]      plane;
   } tgi_cfg_type;

   // one classified item between front and back
   typedef struct packed {
      logic          kind;
      logic          wr_ok;
      logic [31:0]   wr_value;
      logic          oor;
      logic [47:0]   base;
      logic [FRAC_MAX-1:0] fx;
      logic [FRAC_MAX-1:0] fy;
      logic [FRAC_MAX-1:0] fz;
   } tgi_item_type;

   typedef struct packed {
      logic        oor;
      logic [31:0] density;
   } tgi_result_type;

endpackage

>>> src/trilinear_grid_interpolator.sv
// trilinear grid interpolator: one item per cycle sustained while rsp_tready keeps up
// front, queue and back decoupled: 6 front stages, the queue, then 8 back stages
// the eight corner reads use eight replicated grid rams, one read port each
// reset sets config defaults, clears valids, credits, queues; rams undefined until written
// depends on tgi_pkg, tgi_front, tgi_queue, tgi_back, tgi_ram
module trilinear_grid_interpolator #(
   parameter int GRID_WORDS = tgi_pkg::GRID_WORDS_DEF,
   parameter int FRAC_BITS  = tgi_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // item input
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // write_addr[17:0], write_value[49:18], point_x[97:50], point_y[145:98],
   // point_z[193:146], zero fill above
   input  logic [tgi_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_type
   input  logic                            req_tuser,
   // result output
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // density[31:0]
   output logic [31:0]                     rsp_tdata,
   // out_of_range
   output logic                            rsp_tuser,
   // configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tgi_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tgi_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tgi_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import tgi_pkg::*;

   logic [2:0][47:0] origin_ff;
   logic [2:0][31:0] inv_step_ff;
   logic [10:0]      count_x_ff, count_y_ff;
   logic [21:0]      plane_ff;
   logic             csr_wr;
   logic [2:0]       csr_idx;
   tgi_cfg_type      cfg;

   logic             q_push, q_pop, q_empty;
   tgi_item_type     q_push_item, q_pop_item;
   logic             out_push, out_pop, out_empty;
   tgi_result_type   out_in, out_head;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[5:3];

   // register file, 8-byte spacing
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff   <= '0;
         inv_step_ff <= {3{32'hFFFF_FFFF}};
         count_x_ff  <= 11'd64;
         count_y_ff  <= 11'd64;
         plane_ff    <= 22'd4096;
      end else begin
         if (csr_wr) begin
            case (csr_idx)
               REG_ORIGIN_X:   origin_ff[0]   <= csr_pwdata[47:0];
               REG_ORIGIN_Y:   origin_ff[1]   <= csr_pwdata[47:0];
               REG_ORIGIN_Z:   origin_ff[2]   <= csr_pwdata[47:0];
               REG_INV_STEP_X: inv_step_ff[0] <= csr_pwdata[31:0];
               REG_INV_STEP_Y: inv_step_ff[1] <= csr_pwdata[31:0];
               REG_INV_STEP_Z: inv_step_ff[2] <= csr_pwdata[31:0];
               REG_COUNT_X:    count_x_ff     <= csr_pwdata[10:0];
               REG_COUNT_Y:    count_y_ff     <= csr_pwdata[10:0];
               default: ;
            endcase
         end
         // plane size follows the counts, registered in the cycle after they change
         plane_ff <= 22'(count_x_ff) * 22'(count_y_ff);
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ORIGIN_X:   csr_prdata = 64'(origin_ff[0]);
         REG_ORIGIN_Y:   csr_prdata = 64'(origin_ff[1]);
         REG_ORIGIN_Z:   csr_prdata = 64'(origin_ff[2]);
         REG_INV_STEP_X: csr_prdata = 64'(inv_step_ff[0]);
         REG_INV_STEP_Y: csr_prdata = 64'(inv_step_ff[1]);
         REG_INV_STEP_Z: csr_prdata = 64'(inv_step_ff[2]);
         REG_COUNT_X:    csr_prdata = 64'(count_x_ff);
         REG_COUNT_Y:    csr_prdata = 64'(count_y_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.origin   = origin_ff;
      cfg.inv_step = inv_step_ff;
      cfg.count_x  = count_x_ff;
      cfg.count_y  = count_y_ff;
      cfg.plane    = plane_ff;
   end

   // front: offset, scale, cell index, bounds and base address
   tgi_front #(
      .GRID_WORDS(GRID_WORDS),
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_kind(req_tuser),
      .req_data(req_tdata),
      .push(q_push),
      .push_item(q_push_item),
      .pop(q_pop)
   );

   // queue between front and back, front holds credits for it
   tgi_queue #(
      .WIDTH($bits(tgi_item_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_item_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(q_push_item),
      .pop(q_pop),
      .pop_data(q_pop_item),
      .empty(q_empty)
   );

   // back: grid writes, corner reads and the seven blends
   tgi_back #(
      .GRID_WORDS(GRID_WORDS),
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .q_empty(q_empty),
      .q_item(q_pop_item),
      .q_pop(q_pop),
      .out_push(out_push),
      .out_result(out_in),
      .out_pop(out_pop)
   );

   // output queue, back reserves a slot before it takes an item
   tgi_queue #(
      .WIDTH($bits(tgi_result_type)),
      .DEPTH(OUT_DEPTH)
   ) u_out_queue (
      .clock(clock),
      .reset(reset),
      .push(out_push),
      .push_data(out_in),
      .pop(out_pop),
      .pop_data(out_head),
      .empty(out_empty)
   );

   assign rsp_tvalid = !out_empty;
   assign out_pop    = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = out_head.density;
   assign rsp_tuser  = out_head.oor;
endmodule

>>> src/tgi_ram.sv
// generic single-write, single-read ram with registered read data
// no package dependencies
module tgi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> src/tgi_queue.sv
// small register fifo, head shown combinationally
// no package dependencies
module tgi_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
endmodule

>>> src/tgi_front.sv
// front: accepts items, maps query points to cell base address and fractions
// depends on tgi_pkg
module tgi_front #(
   parameter int GRID_WORDS = tgi_pkg::GRID_WORDS_DEF,
   parameter int FRAC_BITS  = tgi_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tgi_pkg::tgi_cfg_type         cfg,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_kind,
   input  logic [tgi_pkg::REQ_DATA_W-1:0] req_data,
   output logic                         push,
   output tgi_pkg::tgi_item_type        push_item,
   input  logic                         pop
);
   import tgi_pkg::*;

   localparam int PW   = 49;
   localparam int IXW  = PW - FRAC_BITS;
   localparam int AW   = $clog2(GRID_WORDS);
   localparam int RW   = $clog2(QUEUE_DEPTH) + 1;

   logic          accept;
   logic [RW-1:0] reserved_ff, reserved_in;
   logic [6:1]    valid_ff, valid_in;
   logic [6:1]    kind_ff;
   logic [6:1]    wok_ff;
   logic [17:0]   waddr_ff [6:1];
   logic [31:0]   wval_ff [6:1];

   logic [REQ_DATA_W-1:0] data_ff;
   logic [48:0]   d_ff [3];
   logic [2:0]    neg3_ff, neg4_ff;
   logic [47:0]   phi_ff [3];
   logic [31:0]   plo_ff [3];
   logic [PW-1:0] pos_ff [3];
   logic          ok5_ff;
   logic [21:0]   m1_ff;
   logic [47:0]   m2_ff;
   logic [10:0]   ix5_ff;
   logic [FRAC_MAX-1:0] f5_ff [3];
   tgi_item_type  item_ff;

   logic [47:0]   pt [3];
   logic [63:0]   lo_prod [3];
   logic [IXW-1:0] idx [3];
   logic          ok5_in;
   logic [47:0]   base_w, top_w;

   assign accept    = req_valid && req_ready;
   assign req_ready = (reserved_ff < RW'(QUEUE_DEPTH));

   // credit: items accepted and not yet taken out of the queue
   always_comb begin
      reserved_in = reserved_ff + RW'(accept) - RW'(pop);
      valid_in    = {valid_ff[5:1], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
         valid_ff    <= '0;
      end else begin
         reserved_ff <= reserved_in;
         valid_ff    <= valid_in;
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         pt[a]      = data_ff[50 + 48*a +: 48];
         lo_prod[a] = 64'(d_ff[a][31:0]) * 64'(cfg.inv_step[a]);
         idx[a]     = pos_ff[a][PW-1:FRAC_BITS];
      end
      ok5_in = (neg4_ff == 3'b000)
         && ((IXW+1)'(idx[0]) + (IXW+1)'(1) < (IXW+1)'(cfg.count_x))
         && ((IXW+1)'(idx[1]) + (IXW+1)'(1) < (IXW+1)'(cfg.count_y))
         && ((IXW+1)'(idx[2]) < (IXW+1)'(GRID_WORDS));
      base_w = 48'(ix5_ff) + 48'(m1_ff) + m2_ff;
      top_w  = base_w + 48'(cfg.plane) + 48'(cfg.count_x) + 48'd1;
   end

   always_ff @(posedge clock) begin
      // stage 1: input register
      kind_ff[1]  <= req_kind;
      data_ff     <= req_data;
      waddr_ff[1] <= req_data[17:0];
      wval_ff[1]  <= req_data[49:18];
      wok_ff[1]   <= (48'(req_data[17:0]) < 48'(GRID_WORDS));
      for (int s = 2; s <= 6; s++) begin
         kind_ff[s]  <= kind_ff[s-1];
         waddr_ff[s] <= waddr_ff[s-1];
         wval_ff[s]  <= wval_ff[s-1];
         wok_ff[s]   <= wok_ff[s-1];
      end
      for (int a = 0; a < 3; a++) begin
         // stage 2: offset from origin
         d_ff[a]    <= {pt[a][47], pt[a]} - {cfg.origin[a][47], cfg.origin[a]};
         // stage 3: partial products of offset and reciprocal
         phi_ff[a]  <= 48'(d_ff[a][47:32]) * 48'(cfg.inv_step[a]);
         plo_ff[a]  <= lo_prod[a][63:32];
         // stage 4: cell position
         pos_ff[a]  <= PW'(phi_ff[a]) + PW'(plo_ff[a]);
         // stage 5: fractions
         f5_ff[a]   <= FRAC_MAX'(pos_ff[a][FRAC_BITS-1:0]);
      end
      neg3_ff <= {d_ff[2][48], d_ff[1][48], d_ff[0][48]};
      neg4_ff <= neg3_ff;
      // stage 5: bounds and address products
      ok5_ff <= ok5_in;
      ix5_ff <= idx[0][10:0];
      m1_ff  <= 22'(cfg.count_x) * 22'(idx[1][10:0]);
      m2_ff  <= 48'(48'(cfg.plane) * 48'(idx[2][AW-1:0]));
      // stage 6: base address and memory bound
      item_ff.kind     <= kind_ff[5];
      item_ff.wr_ok    <= wok_ff[5];
      item_ff.wr_value <= wval_ff[5];
      item_ff.oor      <= !ok5_ff || (top_w >= 48'(GRID_WORDS));
      item_ff.base     <= (kind_ff[5] == REQ_WRITE) ? 48'(waddr_ff[5]) : base_w;
      item_ff.fx       <= f5_ff[0];
      item_ff.fy       <= f5_ff[1];
      item_ff.fz       <= f5_ff[2];
   end

   assign push      = valid_ff[6];
   assign push_item = item_ff;
endmodule

>>> src/tgi_back.sv
// back: reads the eight corners from replicated grid rams and blends them
// depends on tgi_pkg and tgi_ram
module tgi_back #(
   parameter int GRID_WORDS = tgi_pkg::GRID_WORDS_DEF,
   parameter int FRAC_BITS  = tgi_pkg::FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tgi_pkg::tgi_cfg_type    cfg,
   input  logic                    q_empty,
   input  tgi_pkg::tgi_item_type   q_item,
   output logic                    q_pop,
   output logic                    out_push,
   output tgi_pkg::tgi_result_type out_result,
   input  logic                    out_pop
);
   import tgi_pkg::*;

   localparam int AW  = $clog2(GRID_WORDS);
   localparam int OW  = $clog2(OUT_DEPTH) + 1;
   localparam int PRW = 32 + FRAC_BITS + 1;
   localparam logic [FRAC_BITS:0] ONE  = (FRAC_BITS+1)'(1) << FRAC_BITS;
   localparam logic [PRW:0]       HALF = (PRW+1)'(1) << (FRAC_BITS-1);

   logic [OW-1:0] occ_ff, occ_in;
   logic [8:1]    valid_ff, valid_in;
   logic [8:1]    kind_ff, oor_ff;
   logic          wr_done;

   tgi_item_type  item_ff;
   logic [FRAC_BITS-1:0] fx_ff [3:2];
   logic [FRAC_BITS-1:0] fy_ff [5:2];
   logic [FRAC_BITS-1:0] fz_ff [7:2];
   logic [47:0]   offs [8];
   logic [AW-1:0] raddr [8];
   logic [31:0]   rdata [8];
   logic [PRW-1:0] px_ff [8];
   logic [31:0]   cx_ff [4];
   logic [PRW-1:0] py_ff [4];
   logic [31:0]   cy_ff [2];
   logic [PRW-1:0] pz_ff [2];
   logic [PRW:0]  sx [4];
   logic [PRW:0]  sy [2];
   logic [PRW:0]  sz;
   tgi_result_type res_ff;
   logic          we;

   assign q_pop   = !q_empty && (occ_ff < OW'(OUT_DEPTH));
   assign wr_done = valid_ff[8] && (kind_ff[8] == REQ_WRITE);

   // credit: items taken from the queue whose slot in the output queue is not free yet
   always_comb begin
      occ_in   = occ_ff + OW'(q_pop) - OW'(wr_done) - OW'(out_pop);
      valid_in = {valid_ff[7:1], q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff   <= '0;
         valid_ff <= '0;
      end else begin
         occ_ff   <= occ_in;
         valid_ff <= valid_in;
      end
   end

   // corner offsets, in blend order: x pairs of rows y0z0, y1z0, y0z1, y1z1
   always_comb begin
      offs[0] = 48'd0;
      offs[1] = 48'd1;
      offs[2] = 48'(cfg.count_x);
      offs[3] = 48'(cfg.count_x) + 48'd1;
      offs[4] = 48'(cfg.plane);
      offs[5] = 48'(cfg.plane) + 48'd1;
      offs[6] = 48'(cfg.plane) + 48'(cfg.count_x);
      offs[7] = 48'(cfg.plane) + 48'(cfg.count_x) + 48'd1;
      for (int i = 0; i < 8; i++) begin
         raddr[i] = AW'(item_ff.base + offs[i]);
      end
      we = valid_ff[1] && (item_ff.kind == REQ_WRITE) && item_ff.wr_ok;
   end

   for (genvar g = 0; g < 8; g++) begin : g_bank
      tgi_ram #(
         .WIDTH(32),
         .DEPTH(GRID_WORDS)
      ) u_ram (
         .clock(clock),
         .we(we),
         .waddr(AW'(item_ff.base)),
         .wdata(item_ff.wr_value),
         .raddr(raddr[g]),
         .rdata(rdata[g])
      );
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sx[k] = (PRW+1)'(px_ff[2*k]) + (PRW+1)'(px_ff[2*k+1]) + HALF;
      end
      for (int k = 0; k < 2; k++) begin
         sy[k] = (PRW+1)'(py_ff[2*k]) + (PRW+1)'(py_ff[2*k+1]) + HALF;
      end
      sz = (PRW+1)'(pz_ff[0]) + (PRW+1)'(pz_ff[1]) + HALF;
   end

   always_ff @(posedge clock) begin
      // stage 1: item taken from the queue
      if (q_pop) begin
         item_ff <= q_item;
      end
      kind_ff[1] <= q_item.kind;
      oor_ff[1]  <= q_item.oor;
      for (int s = 2; s <= 8; s++) begin
         kind_ff[s] <= kind_ff[s-1];
         oor_ff[s]  <= oor_ff[s-1];
      end
      fx_ff[2] <= item_ff.fx[FRAC_BITS-1:0];
      fy_ff[2] <= item_ff.fy[FRAC_BITS-1:0];
      fz_ff[2] <= item_ff.fz[FRAC_BITS-1:0];
      fx_ff[3] <= fx_ff[2];
      for (int s = 3; s <= 5; s++) begin
         fy_ff[s] <= fy_ff[s-1];
      end
      for (int s = 3; s <= 7; s++) begin
         fz_ff[s] <= fz_ff[s-1];
      end
      // stage 3: x weights
      for (int i = 0; i < 8; i += 2) begin
         px_ff[i]   <= PRW'(rdata[i]) * PRW'(ONE - (FRAC_BITS+1)'(fx_ff[2]));
         px_ff[i+1] <= PRW'(rdata[i+1]) * PRW'(fx_ff[2]);
      end
      // stage 4: x blends
      for (int k = 0; k < 4; k++) begin
         cx_ff[k] <= sx[k][FRAC_BITS+31:FRAC_BITS];
      end
      // stage 5: y weights
      for (int i = 0; i < 4; i += 2) begin
         py_ff[i]   <= PRW'(cx_ff[i]) * PRW'(ONE - (FRAC_BITS+1)'(fy_ff[4]));
         py_ff[i+1] <= PRW'(cx_ff[i+1]) * PRW'(fy_ff[4]);
      end
      // stage 6: y blends
      for (int k = 0; k < 2; k++) begin
         cy_ff[k] <= sy[k][FRAC_BITS+31:FRAC_BITS];
      end
      // stage 7: z weights
      pz_ff[0] <= PRW'(cy_ff[0]) * PRW'(ONE - (FRAC_BITS+1)'(fz_ff[6]));
      pz_ff[1] <= PRW'(cy_ff[1]) * PRW'(fz_ff[6]);
      // stage 8: z blend, out-of-range queries give zero
      res_ff.oor     <= oor_ff[7];
      res_ff.density <= oor_ff[7] ? 32'd0 : sz[FRAC_BITS+31:FRAC_BITS];
   end

   assign out_push   = valid_ff[8] && (kind_ff[8] == REQ_QUERY);
   assign out_result = res_ff;
endmodule
